[rtl/tapm_pkg.sv]
// Package for the thrust allocation PWM mapper.
// Holds the transaction payload types, register indexes and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package tapm_pkg;

  // Number of wrench axes and lanes.
  localparam int NumAxes = 6;
  // Number of pipeline stages from input acceptance to the output register.
  localparam int Lat = 24;
  // Quotient bits produced by the scaling divider, one per stage.
  localparam int DivSteps = 16;
  // PWM command for a thrust of exactly zero.
  localparam logic [15:0] PwmNeutral = 16'd1500;
  // Unity gain in Q8.8.
  localparam logic signed [15:0] GainOne = 16'sd256;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgMaxLimit = 3'd0,
    CfgMinLimit = 3'd1,
    CfgRollGain = 3'd2,
    CfgPitchGain = 3'd3,
    CfgYawGain = 3'd4,
    CfgFwdCurve = 3'd5,
    CfgBwdCurve = 3'd6
  } cfg_idx_e;

  // Input transaction: one wrench request in Q8.8.
  typedef struct packed {
    logic signed [15:0] surge_force;
    logic signed [15:0] sway_force;
    logic signed [15:0] heave_force;
    logic signed [15:0] roll_torque;
    logic signed [15:0] pitch_torque;
    logic signed [15:0] yaw_torque;
  } in_item_t;

  // Output transaction: one PWM command per axis.
  typedef struct packed {
    logic [15:0] surge_pwm;
    logic [15:0] sway_pwm;
    logic [15:0] heave_pwm;
    logic [15:0] roll_pwm;
    logic [15:0] pitch_pwm;
    logic [15:0] yaw_pwm;
  } out_item_t;

  // Quadratic curve coefficients, each signed Q8.8.
  typedef struct packed {
    logic signed [15:0] quad;
    logic signed [15:0] lin;
    logic signed [15:0] cnst;
  } curve_t;

  // Common scale ratio lim/e handed from the merge stage to the lanes.
  typedef struct packed {
    logic [15:0] e;
    logic [15:0] lim;
  } scale_t;

endpackage

[rtl/tapm_gain.sv]
// Front lane stage of the thrust allocation PWM mapper: applies one axis gain.
// No dependencies.
`timescale 1ns / 1ps

module tapm_gain (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] val_i,
  input  logic signed [15:0] gain_i,
  output logic signed [15:0] thr_o
);

  logic signed [31:0] prod;
  logic signed [31:0] adj;
  logic signed [23:0] quo;
  logic signed [15:0] thr_d;
  logic signed [15:0] thr_q;

  // Q8.8 product, divided by 256 with truncation toward zero, then saturated.
  always_comb begin
    prod = val_i * gain_i;
    adj = prod + ((prod < 0) ? 32'sd255 : 32'sd0);
    quo = adj[31:8];
    if (quo > 24'sd32767) begin
      thr_d = 16'sh7fff;
    end else if (quo < -24'sd32768) begin
      thr_d = 16'sh8000;
    end else begin
      thr_d = quo[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

[rtl/tapm_scale.sv]
// Merge stage of the thrust allocation PWM mapper: finds the extreme thrusts
// over all lanes and picks the common scale ratio. Depends on tapm_pkg.
`timescale 1ns / 1ps

module tapm_scale (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [15:0]   thr_i [tapm_pkg::NumAxes],
  input  logic        [14:0]   max_limit_i,
  input  logic signed [15:0]   min_limit_i,
  output tapm_pkg::scale_t     scale_o,
  output logic signed [15:0]   thr_o [tapm_pkg::NumAxes]
);

  logic signed [15:0] mn_d, mx_d, mn_q, mx_q;
  logic signed [15:0] thr2_q [tapm_pkg::NumAxes];
  logic signed [15:0] thr3_q [tapm_pkg::NumAxes];
  logic signed [15:0] thr4_q [tapm_pkg::NumAxes];
  logic [16:0] amn_w, amx_w, ml_w;
  logic [15:0] ml;
  logic [15:0] xl;
  logic [15:0] e1_d, l1_d, amx_d, e1_q, l1_q, amx_q;
  logic [31:0] p_mx, p_e;
  tapm_pkg::scale_t scale_d, scale_q;

  // Smallest and largest thrust over the lanes.
  always_comb begin
    mn_d = thr_i[0];
    mx_d = thr_i[0];
    for (int i = 1; i < tapm_pkg::NumAxes; i++) begin
      if (thr_i[i] < mn_d) begin
        mn_d = thr_i[i];
      end
      if (thr_i[i] > mx_d) begin
        mx_d = thr_i[i];
      end
    end
  end

  // First candidate: the ratio of the smallest thrust to the lower limit.
  always_comb begin
    amn_w = (mn_q < 0) ? (17'd0 - {mn_q[15], mn_q}) : {1'b0, mn_q};
    amx_w = (mx_q < 0) ? (17'd0 - {mx_q[15], mx_q}) : {1'b0, mx_q};
    ml_w = (min_limit_i < 0) ? (17'd0 - {min_limit_i[15], min_limit_i})
                             : {1'b0, min_limit_i};
    ml = (ml_w == 17'd0) ? 16'd1 : ml_w[15:0];
    amx_d = amx_w[15:0];
    if (amn_w[15:0] > ml) begin
      e1_d = amn_w[15:0];
      l1_d = ml;
    end else begin
      e1_d = 16'd1;
      l1_d = 16'd1;
    end
  end

  // Second candidate: the ratio of the largest thrust to the upper limit.
  always_comb begin
    xl = (max_limit_i == 15'd0) ? 16'd1 : {1'b0, max_limit_i};
    p_mx = amx_q * l1_q;
    p_e = e1_q * xl;
    if (p_mx > p_e) begin
      scale_d.e = amx_q;
      scale_d.lim = xl;
    end else begin
      scale_d.e = e1_q;
      scale_d.lim = l1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mn_q <= mn_d;
      mx_q <= mx_d;
      e1_q <= e1_d;
      l1_q <= l1_d;
      amx_q <= amx_d;
      scale_q <= scale_d;
      for (int i = 0; i < tapm_pkg::NumAxes; i++) begin
        thr2_q[i] <= thr_i[i];
        thr3_q[i] <= thr2_q[i];
        thr4_q[i] <= thr3_q[i];
      end
    end
  end

  assign scale_o = scale_q;
  assign thr_o = thr4_q;

endmodule

[rtl/tapm_lane.sv]
// Back lane of the thrust allocation PWM mapper: scales one thrust by the
// common ratio with a pipelined divider and maps it through a PWM curve.
// Depends on tapm_pkg.
`timescale 1ns / 1ps

module tapm_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] thr_i,
  input  tapm_pkg::scale_t   scale_i,
  input  tapm_pkg::curve_t   fwd_i,
  input  tapm_pkg::curve_t   bwd_i,
  output logic        [15:0] pwm_o
);

  localparam int N = tapm_pkg::DivSteps;

  // Numerator stage.
  logic [16:0] athr;
  logic [30:0] num_q;
  logic [15:0] den_q;
  logic        neg_q;

  // Divider stages.
  logic [15:0] rem_q [N];
  logic [15:0] low_q [N];
  logic [15:0] quo_q [N];
  logic [15:0] dv_q  [N];
  logic        ng_q  [N];
  logic [15:0] rem_in [N];
  logic [15:0] low_in [N];
  logic [15:0] quo_in [N];
  logic [15:0] dv_in  [N];
  logic        ng_in  [N];
  logic [15:0] rem_d [N];
  logic [15:0] quo_d [N];

  // Product and sum stages.
  logic [31:0]        qsq;
  logic signed [16:0] t;
  tapm_pkg::curve_t   cf;
  logic [30:0]        tsq_q;
  logic signed [32:0] bt_q;
  logic signed [15:0] qa_q, qc_q;
  logic               zero_q;
  logic signed [47:0] sum_d, sum_q;
  logic               zero2_q;

  // Magnitude of thrust times the limit; the sign is applied after the divide.
  assign athr = (thr_i < 0) ? (17'd0 - {thr_i[15], thr_i}) : {1'b0, thr_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= 31'(athr[15:0] * scale_i.lim);
      den_q <= scale_i.e;
      neg_q <= thr_i[15];
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < N; k++) begin : g_div
    logic [16:0] trial;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in[k] = {1'b0, num_q[30:16]};
      assign low_in[k] = num_q[15:0];
      assign quo_in[k] = 16'd0;
      assign dv_in[k] = den_q;
      assign ng_in[k] = neg_q;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign dv_in[k] = dv_q[k-1];
      assign ng_in[k] = ng_q[k-1];
    end
    assign trial = {rem_in[k], low_in[k][15]};
    assign ge = (trial >= {1'b0, dv_in[k]});
    assign rem_d[k] = ge ? 16'(trial - {1'b0, dv_in[k]}) : trial[15:0];
    assign quo_d[k] = {quo_in[k][14:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= {low_in[k][14:0], 1'b0};
        quo_q[k] <= quo_d[k];
        dv_q[k] <= dv_in[k];
        ng_q[k] <= ng_in[k];
      end
    end
  end

  // Signed scaled thrust, its square and the linear term.
  always_comb begin
    t = ng_q[N-1] ? (17'sd0 - $signed({1'b0, quo_q[N-1]})) : $signed({1'b0, quo_q[N-1]});
    qsq = quo_q[N-1] * quo_q[N-1];
    cf = ng_q[N-1] ? bwd_i : fwd_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tsq_q <= qsq[30:0];
      bt_q <= cf.lin * t;
      qa_q <= cf.quad;
      qc_q <= cf.cnst;
      zero_q <= (quo_q[N-1] == 16'd0);
    end
  end

  // Curve value with 24 fraction bits.
  always_comb begin
    sum_d = 48'(qa_q * $signed({1'b0, tsq_q}))
          + ({{15{bt_q[32]}}, bt_q} <<< 8)
          + ({{32{qc_q[15]}}, qc_q} <<< 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      zero2_q <= zero_q;
    end
  end

  // Truncate the fraction and saturate; a zero scaled thrust gives the neutral command.
  always_comb begin
    if (zero2_q) begin
      pwm_o = tapm_pkg::PwmNeutral;
    end else if (sum_q < 0) begin
      pwm_o = 16'd0;
    end else if (sum_q[46:40] != 7'd0) begin
      pwm_o = 16'hffff;
    end else begin
      pwm_o = sum_q[39:24];
    end
  end

endmodule

[rtl/thrust_allocation_pwm_mapper.sv]
// Thrust allocation PWM mapper, top level.
// Depends on tapm_pkg, tapm_gain, tapm_scale and tapm_lane.
//
// Usage: one input transaction carries a six-axis wrench request in Q8.8 and
// yields one output transaction of six PWM commands. Both channels use valid
// and stall; a transaction moves at a clock edge with valid high and stall
// low. Configuration registers are written over a separate valid/ready port
// (ready is always high) and should only change while the block is idle.
// A new request may enter every cycle unless the receiver stalls a pending
// result; throughput is one transaction per cycle, as the 16-stage divider in
// each lane is fully pipelined. The six lanes apply gains, a merge stage finds
// the extreme thrusts and the common scale ratio, and each lane then divides
// and evaluates its PWM curve.
// When the receiver stalls with a result pending, the whole pipeline holds and
// the input channel is stalled in the same cycle. Reset clears the pipeline
// valid bits and loads the register defaults (limits of +/-22.0, unity gains,
// zero curves); the block accepts input in the first cycle after reset.
`timescale 1ns / 1ps

module thrust_allocation_pwm_mapper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tapm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tapm_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i
);

  localparam int NA = tapm_pkg::NumAxes;
  localparam int L = tapm_pkg::Lat;

  logic [14:0]        max_lim_q;
  logic signed [15:0] min_lim_q;
  logic signed [15:0] roll_gain_q, pitch_gain_q, yaw_gain_q;
  tapm_pkg::curve_t   fwd_q, bwd_q;

  logic               en;
  logic [L-1:0]       vld_q;
  logic signed [15:0] val [NA];
  logic signed [15:0] gain [NA];
  logic signed [15:0] thr1 [NA];
  logic signed [15:0] thr4 [NA];
  tapm_pkg::scale_t   scale;
  logic [15:0]        pwm [NA];
  tapm_pkg::out_item_t out_d, out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lim_q <= 15'd5632;
      min_lim_q <= -16'sd5632;
      roll_gain_q <= tapm_pkg::GainOne;
      pitch_gain_q <= tapm_pkg::GainOne;
      yaw_gain_q <= tapm_pkg::GainOne;
      fwd_q <= '0;
      bwd_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tapm_pkg::cfg_idx_e'(cfg_index_i))
        tapm_pkg::CfgMaxLimit: max_lim_q <= cfg_data_i[14:0];
        tapm_pkg::CfgMinLimit: min_lim_q <= cfg_data_i[15:0];
        tapm_pkg::CfgRollGain: roll_gain_q <= cfg_data_i[15:0];
        tapm_pkg::CfgPitchGain: pitch_gain_q <= cfg_data_i[15:0];
        tapm_pkg::CfgYawGain: yaw_gain_q <= cfg_data_i[15:0];
        tapm_pkg::CfgFwdCurve: fwd_q <= cfg_data_i;
        tapm_pkg::CfgBwdCurve: bwd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held by the receiver.
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[L-1];

  // Per-axis input values and gains; forces have unity gain.
  assign val[0] = in_data_i.surge_force;
  assign val[1] = in_data_i.sway_force;
  assign val[2] = in_data_i.heave_force;
  assign val[3] = in_data_i.roll_torque;
  assign val[4] = in_data_i.pitch_torque;
  assign val[5] = in_data_i.yaw_torque;
  assign gain[0] = tapm_pkg::GainOne;
  assign gain[1] = tapm_pkg::GainOne;
  assign gain[2] = tapm_pkg::GainOne;
  assign gain[3] = roll_gain_q;
  assign gain[4] = pitch_gain_q;
  assign gain[5] = yaw_gain_q;

  for (genvar i = 0; i < NA; i++) begin : g_front
    tapm_gain u_gain (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (val[i]),
      .gain_i (gain[i]),
      .thr_o  (thr1[i])
    );
  end

  tapm_scale u_scale (
    .clk_i       (clk_i),
    .en_i        (en),
    .thr_i       (thr1),
    .max_limit_i (max_lim_q),
    .min_limit_i (min_lim_q),
    .scale_o     (scale),
    .thr_o       (thr4)
  );

  for (genvar i = 0; i < NA; i++) begin : g_back
    tapm_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .thr_i   (thr4[i]),
      .scale_i (scale),
      .fwd_i   (fwd_q),
      .bwd_i   (bwd_q),
      .pwm_o   (pwm[i])
    );
  end

  // Output register.
  always_comb begin
    out_d.surge_pwm = pwm[0];
    out_d.sway_pwm = pwm[1];
    out_d.heave_pwm = pwm[2];
    out_d.roll_pwm = pwm[3];
    out_d.pitch_pwm = pwm[4];
    out_d.yaw_pwm = pwm[5];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // An accepted request enters the first pipeline stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // The input is stalled only while a result is held at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // The scale ratio never exceeds one.
  a_scale_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> scale.e >= scale.lim && scale.e != 16'd0)
    else $error("scale ratio out of range");

endmodule
